[hdl/assert_macros.svh]
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/ps2ied_pkg.sv]
package ps2ied_pkg;

   localparam logic [7:0] EXT_PREFIX   = 8'hE0;
   localparam int unsigned HDR_SYNC_BIT = 3;
   localparam int unsigned HDR_XSGN_BIT = 4;
   localparam int unsigned HDR_YSGN_BIT = 5;

   localparam logic SRC_KEYBOARD = 1'b0;
   localparam logic SRC_MOUSE    = 1'b1;

   localparam logic EVENT_KEY  = 1'b0;
   localparam logic EVENT_MOVE = 1'b1;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_X      = 2'd1,
      PHASE_Y      = 2'd2,
      PHASE_SCROLL = 2'd3
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] code;
      logic       high_bit;
   } kbd_result_type;

   typedef struct packed {
      logic              valid;
      logic signed [8:0] move_x;
      logic signed [8:0] move_y;
      logic signed [7:0] scroll;
   } mouse_result_type;

endpackage

[hdl/ps2ied_kbd.sv]
`include "assert_macros.svh"

module ps2ied_kbd (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic [7:0]                 data_byte,
   output ps2ied_pkg::kbd_result_type result
);
   import ps2ied_pkg::*;

   logic ext_ff;
   logic ext_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff <= 1'b0;
      end else begin
         ext_ff <= ext_in;
      end
   end

   always_comb begin
      ext_in          = ext_ff;
      result.valid    = 1'b0;
      result.code     = {ext_ff, data_byte[6:0]};
      result.high_bit = data_byte[7];
      if (fire) begin
         if (ext_ff) begin
            ext_in       = 1'b0;
            result.valid = 1'b1;
         end else if (data_byte == EXT_PREFIX) begin
            ext_in = 1'b1;
         end else begin
            result.valid = 1'b1;
         end
      end
   end

   `ASSERT_CLK(a_ext_gives_key, fire && ext_ff |-> result.valid && result.code[7], "extended byte lost")
   `ASSERT_CLK(a_prefix_arms, fire && !ext_ff && data_byte == EXT_PREFIX |=> ext_ff, "prefix not armed")
   `ASSERT_ALWAYS(a_no_idle_key, !fire |-> !result.valid, "key word without byte")

endmodule

[hdl/ps2ied_mouse.sv]
`include "assert_macros.svh"

module ps2ied_mouse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [7:0]                   data_byte,
   input  logic                         wheel_mode,
   output ps2ied_pkg::mouse_result_type result
);
   import ps2ied_pkg::*;

   phase_type  phase_ff;
   phase_type  phase_in;
   logic [7:0] header_ff;
   logic [7:0] x_ff;
   logic [7:0] y_ff;
   logic [7:0] y_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         unique case (phase_ff)
            PHASE_HEADER: header_ff <= data_byte;
            PHASE_X:      x_ff      <= data_byte;
            PHASE_Y:      y_ff      <= data_byte;
            default:      ;
         endcase
      end
   end

   assign y_byte = (phase_ff == PHASE_Y) ? data_byte : y_ff;

   always_comb begin
      phase_in      = phase_ff;
      result.valid  = 1'b0;
      result.move_x = $signed({header_ff[HDR_XSGN_BIT], x_ff});
      result.move_y = $signed({header_ff[HDR_YSGN_BIT], y_byte});
      result.scroll = '0;
      if (fire) begin
         unique case (phase_ff)
            PHASE_HEADER: begin
               if (data_byte[HDR_SYNC_BIT]) begin
                  phase_in = PHASE_X;
               end
            end
            PHASE_X: begin
               phase_in = PHASE_Y;
            end
            PHASE_Y: begin
               if (wheel_mode) begin
                  phase_in = PHASE_SCROLL;
               end else begin
                  phase_in     = PHASE_HEADER;
                  result.valid = 1'b1;
               end
            end
            default: begin
               phase_in      = PHASE_HEADER;
               result.valid  = 1'b1;
               result.scroll = wheel_mode ? $signed(data_byte) : 8'sd0;
            end
         endcase
      end
   end

   `ASSERT_CLK(a_emit_at_end, result.valid |-> fire && (phase_ff == PHASE_Y || phase_ff == PHASE_SCROLL), "move word mid packet")
   `ASSERT_CLK(a_three_byte, fire && phase_ff == PHASE_Y && !wheel_mode |=> phase_ff == PHASE_HEADER, "packet did not close")
   `ASSERT_CLK(a_sync_hold, fire && phase_ff == PHASE_HEADER && !data_byte[HDR_SYNC_BIT] |=> phase_ff == PHASE_HEADER, "left sync without header")

endmodule

[hdl/ps2_input_event_decoder.sv]
// PS/2 input event decoder: takes one received byte per word on req_, tagged by
// req_action as keyboard (0) or mouse (1), and returns key and mouse move events
// on rsp_. A keyboard 0xE0 prefix produces no event and marks the next key
// code as extended; mouse bytes are gathered into three-byte packets, or
// four-byte packets while csr_write_data last set wheel mode, and a full packet
// produces one move event. Each byte passes through one input register and
// one result register with the decode between them. A new byte is taken every
// cycle as long as rsp_ is drained; with rsp_ stalled one further byte is
// absorbed by the input register.
`include "assert_macros.svh"

module ps2_input_event_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_event_kind,
   output logic [7:0]        rsp_key_code,
   output logic              rsp_key_high_bit,
   output logic signed [8:0] rsp_move_x,
   output logic signed [8:0] rsp_move_y,
   output logic signed [7:0] rsp_scroll_step
);
   import ps2ied_pkg::*;

   logic             wheel_ff;
   logic             in_valid_ff;
   logic             in_action_ff;
   logic [7:0]       in_byte_ff;
   logic             advance;
   logic             out_valid_ff;
   logic             out_valid_in;
   logic             has_result;
   kbd_result_type   kbd_res;
   mouse_result_type mouse_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_ff <= 1'b0;
      end else if (csr_write_enable) begin
         wheel_ff <= csr_write_data;
      end
   end

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_data_byte;
      end
   end

   ps2ied_kbd u_kbd (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance && in_action_ff == SRC_KEYBOARD),
      .data_byte (in_byte_ff),
      .result    (kbd_res)
   );

   ps2ied_mouse u_mouse (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance && in_action_ff == SRC_MOUSE),
      .data_byte  (in_byte_ff),
      .wheel_mode (wheel_ff),
      .result     (mouse_res)
   );

   assign has_result = kbd_res.valid || mouse_res.valid;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (has_result) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // load the result word
   always_ff @(posedge clock) begin
      if (kbd_res.valid) begin
         rsp_event_kind   <= EVENT_KEY;
         rsp_key_code     <= kbd_res.code;
         rsp_key_high_bit <= kbd_res.high_bit;
         rsp_move_x       <= '0;
         rsp_move_y       <= '0;
         rsp_scroll_step  <= '0;
      end else if (mouse_res.valid) begin
         rsp_event_kind   <= EVENT_MOVE;
         rsp_key_code     <= '0;
         rsp_key_high_bit <= 1'b0;
         rsp_move_x       <= mouse_res.move_x;
         rsp_move_y       <= mouse_res.move_y;
         rsp_scroll_step  <= mouse_res.scroll;
      end
   end

   assign rsp_valid = out_valid_ff;

   `ASSERT_CLK(a_one_source, !(kbd_res.valid && mouse_res.valid), "two results for one byte")
   `ASSERT_CLK(a_result_lands, has_result |=> out_valid_ff, "result word dropped")
   `ASSERT_CLK(a_no_overwrite, has_result |-> !out_valid_ff || rsp_ready, "result word overwritten")

endmodule

[test/ps2_input_event_decoder_check.sv]
`timescale 1ns / 1ps

module ps2_input_event_decoder_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_action,
   input  logic [7:0]        req_data_byte,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_event_kind,
   input  logic [7:0]        rsp_key_code,
   input  logic              rsp_key_high_bit,
   input  logic signed [8:0] rsp_move_x,
   input  logic signed [8:0] rsp_move_y,
   input  logic signed [7:0] rsp_scroll_step,
   output int                mismatches,
   output int                outstanding
);
   import ps2ied_pkg::*;

   typedef struct packed {
      logic              kind;
      logic [7:0]        code;
      logic              high_bit;
      logic signed [8:0] dx;
      logic signed [8:0] dy;
      logic signed [7:0] scroll;
   } ps2_event_type;

   ps2_event_type pending_events[$];
   logic          ext_armed;
   phase_type     pkt_phase;
   logic [7:0]    hdr_byte;
   logic [7:0]    x_byte;
   logic [7:0]    y_byte;
   logic          wheel_on;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < 40) begin
         $display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
      end
      mismatches++;
   endtask

   task automatic push_move(input logic [7:0] scroll_byte);
      ps2_event_type ev;
      ev = '0;
      ev.kind = EVENT_MOVE;
      ev.dx = {hdr_byte[HDR_XSGN_BIT], x_byte};
      ev.dy = {hdr_byte[HDR_YSGN_BIT], y_byte};
      ev.scroll = wheel_on ? scroll_byte : 8'h00;
      pending_events.push_back(ev);
   endtask

   task automatic decode_byte(input logic act, input logic [7:0] b);
      ps2_event_type ev;
      ev = '0;
      if (act == SRC_KEYBOARD) begin
         if (!ext_armed && b == EXT_PREFIX) begin
            ext_armed = 1'b1;
         end else begin
            ev.kind = EVENT_KEY;
            ev.code = {ext_armed, b[6:0]};
            ev.high_bit = b[7];
            ext_armed = 1'b0;
            pending_events.push_back(ev);
         end
      end else begin
         case (pkt_phase)
            PHASE_HEADER: begin
               hdr_byte = b;
               if (b[HDR_SYNC_BIT]) pkt_phase = PHASE_X;
            end
            PHASE_X: begin
               x_byte = b;
               pkt_phase = PHASE_Y;
            end
            PHASE_Y: begin
               y_byte = b;
               if (wheel_on) begin
                  pkt_phase = PHASE_SCROLL;
               end else begin
                  pkt_phase = PHASE_HEADER;
                  push_move(8'h00);
               end
            end
            default: begin
               pkt_phase = PHASE_HEADER;
               push_move(b);
            end
         endcase
      end
   endtask

   task automatic check_event();
      ps2_event_type want;
      if (pending_events.size() == 0) begin
         report_mismatch("rsp word with none pending, kind", int'(rsp_event_kind), -1);
      end else begin
         want = pending_events.pop_front();
         if (rsp_event_kind !== want.kind)
            report_mismatch("event_kind", int'(rsp_event_kind), int'(want.kind));
         if (rsp_key_code !== want.code)
            report_mismatch("key_code", int'(rsp_key_code), int'(want.code));
         if (rsp_key_high_bit !== want.high_bit)
            report_mismatch("key_high_bit", int'(rsp_key_high_bit), int'(want.high_bit));
         if (rsp_move_x !== want.dx)
            report_mismatch("move_x", int'($signed(rsp_move_x)), int'($signed(want.dx)));
         if (rsp_move_y !== want.dy)
            report_mismatch("move_y", int'($signed(rsp_move_y)), int'($signed(want.dy)));
         if (rsp_scroll_step !== want.scroll)
            report_mismatch("scroll_step", int'($signed(rsp_scroll_step)),
                            int'($signed(want.scroll)));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ext_armed = 1'b0;
         pkt_phase = PHASE_HEADER;
         hdr_byte  = 8'h00;
         x_byte    = 8'h00;
         y_byte    = 8'h00;
         wheel_on  = 1'b0;
         pending_events.delete();
      end else begin
         if (req_valid && req_ready) decode_byte(req_action, req_data_byte);
         if (rsp_valid && rsp_ready) check_event();
         if (csr_write_enable) wheel_on = csr_write_data;
      end
      outstanding <= pending_events.size();
   end

endmodule

[test/ps2_input_event_decoder_test.sv]
`timescale 1ns / 1ps

module ps2_input_event_decoder_test;
   import ps2ied_pkg::*;

   localparam int PHASE_ITEMS   = 230;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int TIMEOUT_NS    = 1000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data = 1'b0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_action = SRC_KEYBOARD;
   logic [7:0]        req_data_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_event_kind;
   logic [7:0]        rsp_key_code;
   logic              rsp_key_high_bit;
   logic signed [8:0] rsp_move_x;
   logic signed [8:0] rsp_move_y;
   logic signed [7:0] rsp_scroll_step;

   int   mismatches;
   int   outstanding;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   word_count = 0;
   int   hold_left = 0;
   logic hold_arm = 1'b0;
   logic hold_used = 1'b0;
   logic wheel_on = 1'b0;

   ps2_input_event_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_key_code     (rsp_key_code),
      .rsp_key_high_bit (rsp_key_high_bit),
      .rsp_move_x       (rsp_move_x),
      .rsp_move_y       (rsp_move_y),
      .rsp_scroll_step  (rsp_scroll_step)
   );

   ps2_input_event_decoder_check event_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_key_code     (rsp_key_code),
      .rsp_key_high_bit (rsp_key_high_bit),
      .rsp_move_x       (rsp_move_x),
      .rsp_move_y       (rsp_move_y),
      .rsp_scroll_step  (rsp_scroll_step),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always #2 clock = ~clock;

   // hold off the receiver once, long enough to back up the input
   always @(posedge clock) begin
      if (hold_arm && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(7))
         0: rand_byte = 8'h00;
         1: rand_byte = 8'hFF;
         2: rand_byte = 8'h7F;
         3: rand_byte = 8'h80;
         default: rand_byte = 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_word(input logic act, input logic [7:0] b, input bit counted);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (counted) word_count++;
   endtask

   task automatic set_wheel(input logic mode);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      wheel_on = mode;
   endtask

   task automatic send_key();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         send_word(SRC_KEYBOARD, EXT_PREFIX, 1);
         send_word(SRC_KEYBOARD, EXT_PREFIX, 1);
      end else if (pick < 30) begin
         send_word(SRC_KEYBOARD, EXT_PREFIX, 1);
         send_word(SRC_KEYBOARD, rand_byte(), 1);
      end else begin
         send_word(SRC_KEYBOARD, rand_byte(), 1);
      end
   endtask

   task automatic send_packet();
      int last;
      send_word(SRC_MOUSE, rand_byte() | 8'h08, 1);
      last = wheel_on ? 3 : 2;
      for (int i = 1; i <= last; i++) begin
         if ($urandom_range(9) == 0) send_key();
         send_word(SRC_MOUSE, rand_byte(), 1);
      end
   endtask

   task automatic send_noise();
      if ($urandom_range(2) != 0) begin
         send_word(SRC_MOUSE, rand_byte() & 8'hF7, 0);
      end else begin
         // truncated packet: header and X only
         send_word(SRC_MOUSE, rand_byte() | 8'h08, 0);
         send_word(SRC_MOUSE, rand_byte(), 0);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input logic mode,
                            input logic squeeze);
      int start;
      int pick;
      set_wheel(mode);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (squeeze) hold_arm <= 1'b1;
      start = word_count;
      while (word_count - start < PHASE_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 44) send_key();
         else if (pick < 92) send_packet();
         else send_noise();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_wheel(1'b0);
      send_word(SRC_KEYBOARD, 8'h00, 1);
      send_word(SRC_KEYBOARD, 8'h80, 1);
      send_word(SRC_KEYBOARD, 8'hFF, 1);
      send_word(SRC_KEYBOARD, EXT_PREFIX, 1);
      send_word(SRC_KEYBOARD, 8'h1C, 1);
      send_word(SRC_KEYBOARD, EXT_PREFIX, 1);
      send_word(SRC_KEYBOARD, EXT_PREFIX, 1);
      send_word(SRC_KEYBOARD, EXT_PREFIX, 1);
      send_word(SRC_KEYBOARD, 8'hF0, 1);
      send_word(SRC_MOUSE, 8'h07, 1);
      send_word(SRC_MOUSE, 8'h08, 1);
      send_word(SRC_MOUSE, 8'h00, 1);
      send_word(SRC_MOUSE, 8'h00, 1);
      send_word(SRC_MOUSE, 8'h38, 1);
      send_word(SRC_MOUSE, 8'hFF, 1);
      send_word(SRC_MOUSE, 8'h80, 1);
      send_word(SRC_MOUSE, 8'h18, 1);
      send_word(SRC_KEYBOARD, 8'h5A, 1);
      send_word(SRC_MOUSE, 8'h01, 1);
      // switch to wheel mode before the Y byte
      set_wheel(1'b1);
      send_word(SRC_MOUSE, 8'hFE, 1);
      send_word(SRC_MOUSE, 8'h80, 1);
      send_word(SRC_MOUSE, 8'h28, 1);
      send_word(SRC_MOUSE, 8'h7F, 1);
      send_word(SRC_MOUSE, 8'h01, 1);
      // drop wheel mode while the scroll byte is due
      set_wheel(1'b0);
      send_word(SRC_MOUSE, 8'h7F, 1);

      run_phase(0, 0, 1'b1, 1'b0);
      run_phase(59, 0, 1'b0, 1'b0);
      run_phase(0, 59, 1'b1, 1'b0);
      run_phase(10, 10, 1'b0, 1'b0);
      run_phase(0, 0, 1'b0, 1'b1);
      run_phase(59, 0, 1'b1, 1'b0);
      run_phase(0, 59, 1'b0, 1'b0);
      run_phase(10, 10, 1'b1, 1'b0);

      req_valid <= 1'b0;
      @(posedge clock);
      for (int spin = 0; spin < 5000 && outstanding != 0; spin++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/ps2ied_pkg.sv
hdl/ps2ied_kbd.sv
hdl/ps2ied_mouse.sv
hdl/ps2_input_event_decoder.sv
test/ps2_input_event_decoder_check.sv
test/ps2_input_event_decoder_test.sv
